@@ src/xor_clause_component_grouping_core_defines.svh @@
// assertion macros for the xor clause component grouping core
// no dependencies; included by modules that carry assertions
`ifndef XOR_CLAUSE_COMPONENT_GROUPING_CORE_DEFINES_SVH
`define XOR_CLAUSE_COMPONENT_GROUPING_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define XCCG_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("xccg assertion failed");
`define XCCG_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("xccg assertion failed");
`else
`define XCCG_ASSERT_IMP(name, ante, cons)
`define XCCG_ASSERT_NXT(name, ante, cons)
`endif
`endif

@@ src/xccg_pkg.sv @@
// shared types and constants of the xor clause component grouping core
// no dependencies
package xccg_pkg;

  localparam int unsigned VAR_W   = 10;
  localparam int unsigned LABEL_W = 11;
  localparam int unsigned COUNT_W = 12;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned NUM_VARS = 1024;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [KIND_W-1:0] KIND_QUERY    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TOGETHER = 3'd1;
  localparam logic [KIND_W-1:0] KIND_JOINED   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NEW      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MERGED   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_TOO_LONG = 3'd5;

  typedef struct packed {
    logic             opcode;
    logic [VAR_W-1:0] var_index;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [LABEL_W-1:0] component;
    logic               assigned;
    logic [COUNT_W-1:0] labels_created;
  } out_item_t;

  typedef struct packed {
    logic               has;
    logic [LABEL_W-1:0] label;
  } entry_t;

  typedef struct packed {
    logic clr;
    logic take;
    logic init;
    logic collect;
    logic write;
    logic scan;
    logic emit_q;
    logic emit_c;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic full;
    logic pend_done;
    logic scan_done;
    logic multi;
    logic out_free;
  } ctrl_sts_t;

endpackage

@@ src/xor_clause_component_grouping_core.sv @@
// top level of the xor clause component grouping core
// depends on xccg_pkg, xccg_ctrl and xccg_dp
//
// groups the variables of xor constraints into components. variables come in
// one transaction each, the one with last set closes the constraint and gives
// one result; a query transaction gives the label of one variable. after reset
// the label table is cleared in a pass over all 1024 entries during which no
// input transaction is taken. a query waits for the output to be free before
// the next transaction is taken. closing a constraint reads the labels in
// one pass of the buffer and writes them back in a second pass. when two or
// more components merge, a scan of the whole label table comes between, one
// entry per cycle through the single read port of the table. a constraint
// longer than MAX_XOR_LEN closes with the too-long result and no table pass.
module xor_clause_component_grouping_core #(
  parameter int unsigned MAX_XOR_LEN = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  xccg_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output xccg_pkg::out_item_t out_data_o
);
  import xccg_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // sequencing of clear, collect, scan, write and result phases
  xccg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_opcode_i(in_data_i.opcode),
    .in_last_i  (in_data_i.last),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // label table, constraint buffer and result register
  xccg_dp #(.MAX_XOR_LEN(MAX_XOR_LEN)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

@@ src/xccg_ram.sv @@
// generic single write port ram with registered read
// no dependencies
module xccg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ src/xccg_ctrl.sv @@
// controller state machine of the xor clause component grouping core
// depends on xccg_pkg and the assertion macro header
`include "xor_clause_component_grouping_core_defines.svh"
module xccg_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_opcode_i,
  input  logic               in_last_i,
  output logic               in_ready_o,
  output xccg_pkg::ctrl_cmd_t cmd_o,
  input  xccg_pkg::ctrl_sts_t sts_i
);
  import xccg_pkg::*;

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_COLLECT = 3'd2;
  localparam logic [2:0] ST_SCAN    = 3'd3;
  localparam logic [2:0] ST_WRITE   = 3'd4;
  localparam logic [2:0] ST_EMIT_Q  = 3'd5;
  localparam logic [2:0] ST_EMIT_C  = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          cmd_o.init = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (in_opcode_i == OP_QUERY) begin
            state_d = ST_EMIT_Q;
          end else if (in_last_i) begin
            if (sts_i.full) begin
              state_d = ST_EMIT_C;
            end else begin
              cmd_o.init = 1'b1;
              state_d    = ST_COLLECT;
            end
          end
        end
      end
      ST_COLLECT: begin
        cmd_o.collect = 1'b1;
        if (sts_i.pend_done) begin
          cmd_o.init = 1'b1;
          state_d    = sts_i.multi ? ST_SCAN : ST_WRITE;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          cmd_o.init = 1'b1;
          state_d    = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd_o.write = 1'b1;
        if (sts_i.pend_done) begin
          state_d = ST_EMIT_C;
        end
      end
      ST_EMIT_Q: begin
        if (sts_i.out_free) begin
          cmd_o.emit_q = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_EMIT_C: begin
        if (sts_i.out_free) begin
          cmd_o.emit_c = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  `XCCG_ASSERT_IMP(a_no_take_while_clearing, state_q == ST_CLEAR, !in_ready_o)
  `XCCG_ASSERT_NXT(a_close_goes_collect,
      cmd_o.take && (in_opcode_i == OP_ADD) && in_last_i && !sts_i.full,
      state_q == ST_COLLECT)
  `XCCG_ASSERT_NXT(a_emit_returns_idle, cmd_o.emit_c || cmd_o.emit_q, state_q == ST_IDLE)

endmodule

@@ src/xccg_dp.sv @@
// datapath: label table, constraint buffer, label set and result register
// depends on xccg_pkg and xccg_ram
module xccg_dp #(
  parameter int unsigned MAX_XOR_LEN = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  xccg_pkg::in_item_t  in_data_i,
  input  xccg_pkg::ctrl_cmd_t cmd_i,
  output xccg_pkg::ctrl_sts_t sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output xccg_pkg::out_item_t out_data_o
);
  import xccg_pkg::*;

  localparam int unsigned PendAW = $clog2(MAX_XOR_LEN);
  localparam int unsigned CntW   = $clog2(MAX_XOR_LEN + 1);
  localparam int unsigned IdxW   = VAR_W + 1;
  localparam int unsigned EntW   = $bits(entry_t);

  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               ovf_q, ovf_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic               s1_q, s1_d, s2_q, s2_d;
  logic [VAR_W-1:0]   a1_q;
  logic [LABEL_W-1:0] set_q [MAX_XOR_LEN];
  logic [CntW-1:0]    nlab_q, nlab_d;
  logic               unl_q, unl_d;
  logic [COUNT_W-1:0] next_q, next_d;
  logic               out_vld_q;
  out_item_t          out_q;

  logic               full;
  logic               idx_lt_cnt, idx_lt_num;
  logic               pend_we, pend_re;
  logic [VAR_W-1:0]   pend_rdata;
  logic               var_we, var_re;
  logic [VAR_W-1:0]   var_waddr, var_raddr;
  entry_t             var_wdata;
  logic [EntW-1:0]    var_rdata;
  entry_t             ent;
  logic               hit;
  logic               add_lab;
  logic [LABEL_W-1:0] fresh;
  logic               bump;

  assign ent        = entry_t'(var_rdata);
  assign fresh      = next_q[LABEL_W-1:0];
  assign full       = ovf_q || (cnt_q == CntW'(MAX_XOR_LEN));
  assign idx_lt_cnt = idx_q < IdxW'(cnt_q);
  assign idx_lt_num = idx_q < IdxW'(NUM_VARS);

  // label membership against the distinct labels gathered so far
  always_comb begin
    hit = 1'b0;
    for (int j = 0; j < MAX_XOR_LEN; j++) begin
      if ((set_q[j] == ent.label) && (CntW'(j) < nlab_q)) begin
        hit = 1'b1;
      end
    end
  end

  assign pend_we = cmd_i.take && (in_data_i.opcode == OP_ADD) && !full;
  assign pend_re = (cmd_i.collect || cmd_i.write) && idx_lt_cnt;

  xccg_ram #(.WIDTH(VAR_W), .DEPTH(MAX_XOR_LEN)) u_pend_ram (
    .clk_i  (clk_i),
    .we_i   (pend_we),
    .waddr_i(cnt_q[PendAW-1:0]),
    .wdata_i(in_data_i.var_index),
    .re_i   (pend_re),
    .raddr_i(idx_q[PendAW-1:0]),
    .rdata_o(pend_rdata)
  );

  always_comb begin
    var_re    = (cmd_i.take && (in_data_i.opcode == OP_QUERY)) ||
                (cmd_i.collect && s1_q) || (cmd_i.scan && idx_lt_num);
    var_raddr = cmd_i.take ? in_data_i.var_index :
                cmd_i.collect ? pend_rdata : idx_q[VAR_W-1:0];
    var_we    = cmd_i.clr || (cmd_i.write && s1_q) ||
                (cmd_i.scan && s1_q && ent.has && hit);
    var_waddr = cmd_i.clr ? idx_q[VAR_W-1:0] : cmd_i.write ? pend_rdata : a1_q;
    var_wdata = '0;
    if (!cmd_i.clr) begin
      var_wdata.has   = 1'b1;
      var_wdata.label = (cmd_i.write && (nlab_q == CntW'(1))) ? set_q[0] : fresh;
    end
  end

  xccg_ram #(.WIDTH(EntW), .DEPTH(NUM_VARS)) u_var_ram (
    .clk_i  (clk_i),
    .we_i   (var_we),
    .waddr_i(var_waddr),
    .wdata_i(var_wdata),
    .re_i   (var_re),
    .raddr_i(var_raddr),
    .rdata_o(var_rdata)
  );

  always_comb begin
    cnt_d  = cnt_q;
    ovf_d  = ovf_q;
    idx_d  = idx_q;
    s1_d   = 1'b0;
    s2_d   = 1'b0;
    nlab_d = nlab_q;
    unl_d  = unl_q;
    next_d = next_q;
    bump   = 1'b0;
    if (pend_we) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (cmd_i.take && (in_data_i.opcode == OP_ADD)) begin
      ovf_d = 1'b1;
    end
    if (cmd_i.take) begin
      nlab_d = '0;
      unl_d  = 1'b0;
    end
    if (cmd_i.clr) begin
      idx_d = idx_q + IdxW'(1);
    end else if ((cmd_i.collect || cmd_i.write) && idx_lt_cnt) begin
      idx_d = idx_q + IdxW'(1);
      s1_d  = 1'b1;
    end else if (cmd_i.scan && idx_lt_num) begin
      idx_d = idx_q + IdxW'(1);
      s1_d  = 1'b1;
    end
    if (cmd_i.collect) begin
      s2_d = s1_q;
    end
    add_lab = cmd_i.collect && s2_q && ent.has && !hit;
    if (add_lab) begin
      nlab_d = nlab_q + CntW'(1);
    end
    if (cmd_i.collect && s2_q && !ent.has) begin
      unl_d = 1'b1;
    end
    if (cmd_i.emit_c) begin
      cnt_d = '0;
      ovf_d = 1'b0;
      bump  = !ovf_q && (nlab_q != CntW'(1));
    end
    if (bump) begin
      next_d = next_q + COUNT_W'(1);
    end
    if (cmd_i.init) begin
      idx_d = '0;
      s1_d  = 1'b0;
      s2_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      idx_q     <= '0;
      s1_q      <= 1'b0;
      s2_q      <= 1'b0;
      nlab_q    <= '0;
      unl_q     <= 1'b0;
      next_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      ovf_q  <= ovf_d;
      idx_q  <= idx_d;
      s1_q   <= s1_d;
      s2_q   <= s2_d;
      nlab_q <= nlab_d;
      unl_q  <= unl_d;
      next_q <= next_d;
      if (cmd_i.emit_q || cmd_i.emit_c) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    a1_q <= idx_q[VAR_W-1:0];
    for (int j = 0; j < MAX_XOR_LEN; j++) begin
      if (add_lab && (CntW'(j) == nlab_q)) begin
        set_q[j] <= ent.label;
      end
    end
    if (cmd_i.emit_q) begin
      out_q.kind           <= KIND_QUERY;
      out_q.component      <= ent.has ? ent.label : '0;
      out_q.assigned       <= ent.has;
      out_q.labels_created <= next_q;
    end else if (cmd_i.emit_c) begin
      out_q.labels_created <= next_d;
      out_q.assigned       <= !ovf_q;
      if (ovf_q) begin
        out_q.kind      <= KIND_TOO_LONG;
        out_q.component <= '0;
      end else if (nlab_q == '0) begin
        out_q.kind      <= KIND_NEW;
        out_q.component <= fresh;
      end else if (nlab_q == CntW'(1)) begin
        out_q.kind      <= unl_q ? KIND_JOINED : KIND_TOGETHER;
        out_q.component <= set_q[0];
      end else begin
        out_q.kind      <= KIND_MERGED;
        out_q.component <= fresh;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign sts_o.clr_last  = idx_q == IdxW'(NUM_VARS - 1);
  assign sts_o.full      = full;
  assign sts_o.pend_done = !idx_lt_cnt && !s1_q && !s2_q;
  assign sts_o.scan_done = !idx_lt_num && !s1_q;
  assign sts_o.multi     = nlab_q > CntW'(1);
  assign sts_o.out_free  = !out_vld_q || out_ready_i;

endmodule

@@ verif/testbench.sv @@
// self-checking testbench of xor_clause_component_grouping_core
// depends on xccg_pkg and the core; a built-in label-table predictor checks every result
`timescale 1ns / 1ps

module testbench;
  import xccg_pkg::*;

  localparam int unsigned MAX_LEN = 16;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;

  xor_clause_component_grouping_core #(.MAX_XOR_LEN(MAX_LEN)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  // predictor state: mirror of the label table and the constraint buffer
  logic [LABEL_W-1:0] lbl_mem [NUM_VARS];
  logic               lbl_has [NUM_VARS];
  logic [COUNT_W-1:0] lbl_next;
  logic [VAR_W-1:0]   buf_vars [$];
  logic               buf_ovf;

  out_item_t results_due [$];
  int        n_errors;
  bit        stim_done;
  bit        hold_off;
  bit        feed_on;

  // directed table; want_ok marks rows whose result is typed in
  typedef struct {
    in_item_t  item;
    bit        want_ok;
    out_item_t want;
  } dir_row_t;
  dir_row_t dir_rows [$];

  function automatic void add_row(in_item_t it, bit ok, out_item_t w);
    dir_row_t r;
    r.item = it; r.want_ok = ok; r.want = w;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic out_item_t mk_res(logic [KIND_W-1:0] k, logic [LABEL_W-1:0] c,
                                       logic a, logic [COUNT_W-1:0] n);
    out_item_t r;
    r.kind = k; r.component = c; r.assigned = a; r.labels_created = n;
    return r;
  endfunction

  // fold one transaction into the mirror; returns 1 when a result follows
  function automatic bit label_update(in_item_t it, output out_item_t res);
    logic [LABEL_W-1:0] seen [$];
    logic [LABEL_W-1:0] fresh;
    bit                 all_in;
    bit                 hit;
    if (it.opcode == OP_QUERY) begin
      res = lbl_has[it.var_index] ? mk_res(KIND_QUERY, lbl_mem[it.var_index], 1'b1, lbl_next)
                                  : mk_res(KIND_QUERY, '0, 1'b0, lbl_next);
      return 1;
    end
    if (buf_vars.size() < MAX_LEN) buf_vars.insert(buf_vars.size(), it.var_index);
    else buf_ovf = 1'b1;
    if (!it.last) return 0;
    if (buf_ovf) begin
      res = mk_res(KIND_TOO_LONG, '0, 1'b0, lbl_next);
    end else begin
      foreach (buf_vars[i]) begin
        if (lbl_has[buf_vars[i]]) begin
          hit = 0;
          foreach (seen[j]) if (seen[j] == lbl_mem[buf_vars[i]]) hit = 1;
          if (!hit) seen.insert(seen.size(), lbl_mem[buf_vars[i]]);
        end
      end
      if (seen.size() == 1) begin
        all_in = 1;
        foreach (buf_vars[i]) begin
          if (!lbl_has[buf_vars[i]]) begin
            all_in = 0;
            lbl_mem[buf_vars[i]] = seen[0];
            lbl_has[buf_vars[i]] = 1'b1;
          end
        end
        res = mk_res(all_in ? KIND_TOGETHER : KIND_JOINED, seen[0], 1'b1, lbl_next);
      end else begin
        fresh = lbl_next[LABEL_W-1:0];
        if (seen.size() >= 2) begin
          for (int v = 0; v < NUM_VARS; v++) begin
            if (lbl_has[v]) begin
              foreach (seen[j]) if (seen[j] == lbl_mem[v]) lbl_mem[v] = fresh;
            end
          end
        end
        foreach (buf_vars[i]) begin
          lbl_mem[buf_vars[i]] = fresh;
          lbl_has[buf_vars[i]] = 1'b1;
        end
        lbl_next = lbl_next + 1'b1;
        res = mk_res(seen.size() == 0 ? KIND_NEW : KIND_MERGED, fresh, 1'b1, lbl_next);
      end
    end
    buf_vars.delete();
    buf_ovf = 1'b0;
    return 1;
  endfunction

  task automatic report_mismatch(string what, out_item_t got, out_item_t exp);
    $display("mismatch %s at %0t: got k=%0d c=%0d a=%0d n=%0d exp k=%0d c=%0d a=%0d n=%0d",
             what, $realtime, got.kind, got.component, got.assigned, got.labels_created,
             exp.kind, exp.component, exp.assigned, exp.labels_created);
    n_errors++;
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // short gap most of the time, occasionally a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // send one transaction; valid stays high while back-to-back
  task automatic send(in_item_t it);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // accepted at this edge
    repeat (gap_len()) begin
      in_valid_i <= 1'b0;
      in_data_i  <= in_item_t'($urandom);
      @(posedge clk_i);
    end
  endtask

  function automatic in_item_t mk_in(logic op, int v, logic l);
    in_item_t it;
    it.opcode = op; it.var_index = v[VAR_W-1:0]; it.last = l;
    return it;
  endfunction

  // random constraint: mostly well-formed with a mix of fresh and used variables
  task automatic send_random_constraint();
    int len;
    int pool;
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) len = $urandom_range(MAX_LEN + 1, MAX_LEN + 4);
    else if (r < 10) len = $urandom_range(8, MAX_LEN);
    else len = $urandom_range(1, 5);
    // small pool makes repeats and merges common; sometimes the full range
    pool = ($urandom_range(0, 3) == 0) ? NUM_VARS - 1 : $urandom_range(40, 200);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0)
        send(mk_in(OP_QUERY, $urandom_range(0, pool), 1'($urandom)));
      send(mk_in(OP_ADD, $urandom_range(0, pool), i == len - 1));
    end
  endtask

  // sender
  initial begin
    in_valid_i = 1'b0;
    in_data_i  = '0;
    rst_ni     = 1'b0;
    stim_done  = 0;
    feed_on    = 0;
    n_errors   = 0;
    lbl_next   = '0;
    buf_ovf    = 1'b0;
    for (int v = 0; v < NUM_VARS; v++) begin
      lbl_has[v] = 1'b0;
      lbl_mem[v] = '0;
    end
    // directed rows: extremes, every kind, overflow, query inside a constraint
    add_row(mk_in(OP_QUERY, 0, 0), 1, mk_res(KIND_QUERY, 0, 0, 0));
    add_row(mk_in(OP_QUERY, 1023, 1), 1, mk_res(KIND_QUERY, 0, 0, 0));
    add_row(mk_in(OP_ADD, 0, 0), 0, '0);
    add_row(mk_in(OP_ADD, 1023, 1), 1, mk_res(KIND_NEW, 0, 1, 1));
    add_row(mk_in(OP_ADD, 1023, 0), 0, '0);
    add_row(mk_in(OP_QUERY, 1023, 0), 1, mk_res(KIND_QUERY, 0, 1, 1));
    add_row(mk_in(OP_ADD, 0, 1), 1, mk_res(KIND_TOGETHER, 0, 1, 1));
    add_row(mk_in(OP_ADD, 5, 0), 0, '0);
    add_row(mk_in(OP_ADD, 5, 1), 1, mk_res(KIND_NEW, 1, 1, 2));
    add_row(mk_in(OP_ADD, 682, 0), 0, '0);
    add_row(mk_in(OP_ADD, 341, 0), 0, '0);
    add_row(mk_in(OP_ADD, 0, 1), 1, mk_res(KIND_JOINED, 0, 1, 2));
    add_row(mk_in(OP_ADD, 5, 0), 0, '0);
    add_row(mk_in(OP_ADD, 341, 1), 1, mk_res(KIND_MERGED, 2, 1, 3));
    add_row(mk_in(OP_QUERY, 1023, 0), 1, mk_res(KIND_QUERY, 2, 1, 3));
    for (int i = 0; i <= MAX_LEN; i++)
      add_row(mk_in(OP_ADD, 100 + i, i == MAX_LEN), i == MAX_LEN,
              mk_res(KIND_TOO_LONG, 0, 0, 3));
    add_row(mk_in(OP_QUERY, 100, 0), 1, mk_res(KIND_QUERY, 0, 0, 3));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (dir_rows[i]) begin
      out_item_t res;
      if (label_update(dir_rows[i].item, res)) begin
        if (dir_rows[i].want_ok && res !== dir_rows[i].want)
          report_mismatch("table vs predictor", dir_rows[i].want, res);
        results_due.insert(results_due.size(), dir_rows[i].want_ok ? dir_rows[i].want : res);
      end
      send(dir_rows[i].item);
    end
    // drop valid before the random part so the last directed transaction is not fed twice
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    // random part; the monitor-side predictor below takes over
    feed_on  = 1;
    hold_off = 1;
    for (int k = 0; k < 450; k++) begin
      if ($urandom_range(0, 9) < 2) send(mk_in(OP_QUERY, $urandom, 1'($urandom)));
      else send_random_constraint();
    end
    in_valid_i <= 1'b0;
    stim_done = 1;
  end

  // predictor feed: every accepted input transaction
  always @(posedge clk_i) begin
    out_item_t res;
    if (rst_ni && in_valid_i && in_ready_o && feed_on) begin
      if (label_update(in_data_i, res)) results_due.insert(results_due.size(), res);
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int long_cnt;
    out_ready_i = 1'b0;
    hold_off    = 0;
    long_cnt    = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off && long_cnt < 400) begin
        long_cnt++;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(0, 99) < 3) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(5, 40)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) < 70);
      end
    end
  end

  // checker
  always @(posedge clk_i) begin
    out_item_t exp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (results_due.size() == 0) begin
        report_mismatch("unexpected result", out_data_o, '0);
      end else begin
        exp = results_due.pop_front();
        if (out_data_o.kind !== exp.kind || out_data_o.component !== exp.component ||
            out_data_o.assigned !== exp.assigned ||
            out_data_o.labels_created !== exp.labels_created)
          report_mismatch("field", out_data_o, exp);
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    wait (results_due.size() == 0);
    repeat (2200) @(posedge clk_i);
    if (n_errors == 0 && results_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // timeout
  initial begin
    #60ms;
    $display("FAILURE");
    $finish;
  end

endmodule
